// ===== hdl/ptbe_pkg.sv =====
// Package for the plate trigonometric basis evaluator.
// Holds the shared widths, register indexes, support codes, the CORDIC angle table and
// the saturation helper. It depends on nothing.
package ptbe_pkg;

    localparam int SPAN_W       = 24;
    localparam int MODE_W       = 7;
    localparam int OUT_W        = 32;
    localparam int PHASE_W      = 32;
    localparam int DIV_NUM_W    = 63;
    localparam int CORDIC_STEPS = 24;
    localparam int TRIG_W       = 34;
    localparam int Z_W          = 34;
    localparam int ATAN_W       = 30;
    localparam int PROD_STAGES  = 4;
    localparam int LANE_LAT     = 1 + DIV_NUM_W + CORDIC_STEPS + PROD_STAGES;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_PLATE_LENGTH = 2'd0;
    localparam logic [1:0] REG_PLATE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_SUPPORT_MODE = 2'd2;

    // Edge support codes
    localparam logic [1:0] SUPPORT_HINGED  = 2'd0;
    localparam logic [1:0] SUPPORT_CLAMPED = 2'd1;

    localparam logic [SPAN_W-1:0] SPAN_RESET = 24'd65536;
    localparam logic [29:0] PI_Q28           = 30'd843314857;
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // Rotation angles in turns, 32 fractional bits
    localparam logic [ATAN_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    // Give a magnitude its sign, clipping to the signed output range
    function automatic logic [OUT_W-1:0] sat_q(input logic neg, input logic big,
                                                input logic [OUT_W-2:0] mag);
        logic [OUT_W-1:0] res;
        if (big)
        begin
            res = neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end
        else
        begin
            res = neg ? (~{1'b0, mag} + 1'b1) : {1'b0, mag};
        end
        return res;
    endfunction

endpackage

// ===== hdl/ptbe_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Keeps the low Q_W quotient bits; the divisor is a static register value.
// Depends on ptbe_pkg.
module ptbe_div
    import ptbe_pkg::*;
#(
    parameter int Q_W = 32
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [SPAN_W-1:0]    den,
    output logic [Q_W-1:0]       quo
);

    logic [DIV_NUM_W-1:0] num_reg [DIV_NUM_W];
    logic [SPAN_W-1:0]    rem_reg [DIV_NUM_W];
    logic [Q_W-1:0]       q_reg   [DIV_NUM_W];

    genvar s;
    generate
        for (s = 0; s < DIV_NUM_W; s++)
        begin : g_step
            logic [DIV_NUM_W-1:0] num_in;
            logic [SPAN_W-1:0]    rem_in;
            logic [Q_W-1:0]       q_in;
            logic [SPAN_W:0]      trial;
            logic                 ge;
            logic [SPAN_W-1:0]    rem_next;
            logic [Q_W-1:0]       q_next;

            if (s == 0)
            begin : g_first
                assign num_in = num;
                assign rem_in = '0;
                assign q_in   = '0;
            end
            else
            begin : g_rest
                assign num_in = num_reg[s-1];
                assign rem_in = rem_reg[s-1];
                assign q_in   = q_reg[s-1];
            end

            // Bring down one numerator bit, subtract where it fits
            always_comb
            begin
                trial    = {rem_in, num_in[DIV_NUM_W-1]};
                ge       = trial >= {1'b0, den};
                rem_next = ge ? SPAN_W'(trial - {1'b0, den}) : trial[SPAN_W-1:0];
                q_next   = {q_in[Q_W-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[s] <= num_in << 1;
                    rem_reg[s] <= rem_next;
                    q_reg[s]   <= q_next;
                end
            end
        end
    endgenerate

    assign quo = q_reg[DIV_NUM_W-1];

endmodule

// ===== hdl/ptbe_cordic.sv =====
// Pipelined rotation-mode CORDIC on a 32-bit turn phase, one rotation per stage.
// Gives cosine and sine in Q4.30 after a half-turn fold. Depends on ptbe_pkg.
module ptbe_cordic
    import ptbe_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [PHASE_W-1:0]       phase,
    output logic signed [TRIG_W-1:0] co,
    output logic signed [TRIG_W-1:0] si
);

    logic signed [TRIG_W-1:0] x_reg [CORDIC_STEPS];
    logic signed [TRIG_W-1:0] y_reg [CORDIC_STEPS];
    logic signed [Z_W-1:0]    z_reg [CORDIC_STEPS];
    logic                     flip_reg [CORDIC_STEPS];

    logic                 flip0;
    logic [PHASE_W-1:0]   p0;

    // Fold the phase into the quarter turns around zero
    assign flip0 = phase[PHASE_W-1] ^ phase[PHASE_W-2];
    assign p0    = {phase[PHASE_W-1] ^ flip0, phase[PHASE_W-2:0]};

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++)
        begin : g_rot
            logic signed [TRIG_W-1:0] x_in, y_in;
            logic signed [Z_W-1:0]    z_in;
            logic                     f_in;
            logic signed [Z_W-1:0]    ang;

            if (i == 0)
            begin : g_first
                assign x_in = CORDIC_GAIN_Q30;
                assign y_in = '0;
                assign z_in = Z_W'(signed'(p0));
                assign f_in = flip0;
            end
            else
            begin : g_rest
                assign x_in = x_reg[i-1];
                assign y_in = y_reg[i-1];
                assign z_in = z_reg[i-1];
                assign f_in = flip_reg[i-1];
            end

            assign ang = signed'(Z_W'(ATAN_TURNS[i]));

            // Rotate towards zero residual angle
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    flip_reg[i] <= f_in;
                    if (!z_in[Z_W-1])
                    begin
                        x_reg[i] <= x_in - (y_in >>> i);
                        y_reg[i] <= y_in + (x_in >>> i);
                        z_reg[i] <= z_in - ang;
                    end
                    else
                    begin
                        x_reg[i] <= x_in + (y_in >>> i);
                        y_reg[i] <= y_in - (x_in >>> i);
                        z_reg[i] <= z_in + ang;
                    end
                end
            end
        end
    endgenerate

    // Undo the fold
    assign co = flip_reg[CORDIC_STEPS-1] ? -x_reg[CORDIC_STEPS-1] : x_reg[CORDIC_STEPS-1];
    assign si = flip_reg[CORDIC_STEPS-1] ? -y_reg[CORDIC_STEPS-1] : y_reg[CORDIC_STEPS-1];

endmodule

// ===== hdl/ptbe_lane.sv =====
// One axis lane: phase and angular rate by division, CORDIC, then the derivative products.
// Depends on ptbe_pkg, ptbe_div and ptbe_cordic.
module ptbe_lane
    import ptbe_pkg::*;
#(
    parameter int MAX_MODE  = 64,
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [SPAN_W-1:0] coord,
    input  logic [MODE_W-1:0] mode,
    input  logic [SPAN_W-1:0] span,
    input  logic [1:0]        support,
    output logic [OUT_W-1:0]  value,
    output logic [OUT_W-1:0]  slope,
    output logic [OUT_W-1:0]  curvature
);

    localparam int CM_W    = MODE_W + 1;
    localparam int W_W     = CM_W + 30 + FRAC_BITS;
    localparam int LO_W    = 27;
    localparam int HI_W    = W_W - LO_W;
    localparam int MAG_W   = TRIG_W - 1;
    localparam int PROD_W  = W_W + MAG_W;
    localparam int S1_W    = PROD_W - 30;
    localparam int C_LO_W  = 32;
    localparam int C_HI_W  = S1_W - C_LO_W;
    localparam int SUM_W   = S1_W + W_W;
    localparam int VAL_SH  = 30 - FRAC_BITS;
    localparam int SL_SH   = 58 - FRAC_BITS;
    localparam int CU_SH   = 56 - FRAC_BITS;

    logic hinged;
    assign hinged = (support == SUPPORT_HINGED);

    // Entry: clamp the count and form both numerators
    logic [MODE_W-1:0]    m_c;
    logic [30:0]          px;
    logic [CM_W-1:0]      cm;
    logic [CM_W+29:0]     cpi;
    logic [DIV_NUM_W-1:0] num_p_reg, num_w_reg;

    always_comb
    begin
        m_c = (32'(mode) > MAX_MODE) ? MODE_W'(MAX_MODE) : mode;
        px  = 31'(m_c) * 31'(coord);
        cm  = hinged ? {1'b0, m_c} : {m_c, 1'b0};
        cpi = (CM_W+30)'(cm) * (CM_W+30)'(PI_Q28);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_p_reg <= {(hinged ? {1'b0, px} : {px, 1'b0}), 31'd0};
            num_w_reg <= DIV_NUM_W'({cpi, FRAC_BITS'(0)});
        end
    end

    logic [PHASE_W-1:0] phase;
    logic [W_W-1:0]     w_q;

    ptbe_div #(.Q_W(PHASE_W)) u_div_phase
    (
        .clk (clk),
        .en  (en),
        .num (num_p_reg),
        .den (span),
        .quo (phase)
    );

    ptbe_div #(.Q_W(W_W)) u_div_rate
    (
        .clk (clk),
        .en  (en),
        .num (num_w_reg),
        .den (span),
        .quo (w_q)
    );

    logic signed [TRIG_W-1:0] co, si;

    ptbe_cordic u_cordic
    (
        .clk   (clk),
        .en    (en),
        .phase (phase),
        .co    (co),
        .si    (si)
    );

    // Hold the rate alongside the rotations
    logic [W_W-1:0] w_dly_reg [CORDIC_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_dly_reg[0] <= w_q;
            for (int k = 1; k < CORDIC_STEPS; k++)
            begin
                w_dly_reg[k] <= w_dly_reg[k-1];
            end
        end
    end

    // Stage A: magnitudes and first partial products
    logic [W_W-1:0]            w_c;
    logic [MAG_W-1:0]          mco, msi;
    logic signed [TRIG_W:0]    val;
    logic [LO_W+MAG_W-1:0]     pcl_reg, psl_reg;
    logic [HI_W+MAG_W-1:0]     pch_reg, psh_reg;
    logic [W_W-1:0]            w_a_reg;
    logic                      co_neg_a_reg, si_neg_a_reg, vneg_a_reg;
    logic [TRIG_W-1:0]         vmag_a_reg;

    always_comb
    begin
        w_c = w_dly_reg[CORDIC_STEPS-1];
        mco = co[TRIG_W-1] ? MAG_W'(-co) : MAG_W'(co);
        msi = si[TRIG_W-1] ? MAG_W'(-si) : MAG_W'(si);
        if (hinged)
        begin
            val = (TRIG_W+1)'(si);
        end
        else
        begin
            val = (TRIG_W+1)'(34'sd1073741824) - (TRIG_W+1)'(co);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pcl_reg      <= (LO_W+MAG_W)'(w_c[LO_W-1:0]) * (LO_W+MAG_W)'(mco);
            pch_reg      <= (HI_W+MAG_W)'(w_c[W_W-1:LO_W]) * (HI_W+MAG_W)'(mco);
            psl_reg      <= (LO_W+MAG_W)'(w_c[LO_W-1:0]) * (LO_W+MAG_W)'(msi);
            psh_reg      <= (HI_W+MAG_W)'(w_c[W_W-1:LO_W]) * (HI_W+MAG_W)'(msi);
            w_a_reg      <= w_c;
            co_neg_a_reg <= co[TRIG_W-1];
            si_neg_a_reg <= si[TRIG_W-1];
            vneg_a_reg   <= val[TRIG_W];
            vmag_a_reg   <= val[TRIG_W] ? TRIG_W'(-val) : TRIG_W'(val);
        end
    end

    // Stage B: full products, value and slope finished
    logic [PROD_W-1:0]  prod_c, prod_s, prod_sl, prod_cu, sl_sh;
    logic [TRIG_W-1:0]  v_sh;
    logic               sl_neg, cu_neg;
    logic [OUT_W-1:0]   value_b_reg, slope_b_reg;
    logic [S1_W-1:0]    cu1_b_reg;
    logic               cu_neg_b_reg;
    logic [W_W-1:0]     w_b_reg;

    always_comb
    begin
        prod_c  = PROD_W'(pcl_reg) + (PROD_W'(pch_reg) << LO_W);
        prod_s  = PROD_W'(psl_reg) + (PROD_W'(psh_reg) << LO_W);
        prod_sl = hinged ? prod_c : prod_s;
        prod_cu = hinged ? prod_s : prod_c;
        sl_neg  = hinged ? co_neg_a_reg : si_neg_a_reg;
        cu_neg  = hinged ? !si_neg_a_reg : co_neg_a_reg;
        sl_sh   = prod_sl >> SL_SH;
        v_sh    = vmag_a_reg >> VAL_SH;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_b_reg  <= sat_q(vneg_a_reg, |v_sh[TRIG_W-1:OUT_W-1], v_sh[OUT_W-2:0]);
            slope_b_reg  <= sat_q(sl_neg, |sl_sh[PROD_W-1:OUT_W-1], sl_sh[OUT_W-2:0]);
            cu1_b_reg    <= S1_W'(prod_cu >> 30);
            cu_neg_b_reg <= cu_neg;
            w_b_reg      <= w_a_reg;
        end
    end

    // Stage C: partial products of the second rate factor
    logic [C_LO_W+LO_W-1:0] ll_reg;
    logic [C_LO_W+HI_W-1:0] lh_reg;
    logic [C_HI_W+LO_W-1:0] hl_reg;
    logic [C_HI_W+HI_W-1:0] hh_reg;
    logic [OUT_W-1:0]       value_c_reg, slope_c_reg;
    logic                   cu_neg_c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= (C_LO_W+LO_W)'(cu1_b_reg[C_LO_W-1:0]) * (C_LO_W+LO_W)'(w_b_reg[LO_W-1:0]);
            lh_reg <= (C_LO_W+HI_W)'(cu1_b_reg[C_LO_W-1:0])
                      * (C_LO_W+HI_W)'(w_b_reg[W_W-1:LO_W]);
            hl_reg <= (C_HI_W+LO_W)'(cu1_b_reg[S1_W-1:C_LO_W])
                      * (C_HI_W+LO_W)'(w_b_reg[LO_W-1:0]);
            hh_reg <= (C_HI_W+HI_W)'(cu1_b_reg[S1_W-1:C_LO_W])
                      * (C_HI_W+HI_W)'(w_b_reg[W_W-1:LO_W]);
            value_c_reg  <= value_b_reg;
            slope_c_reg  <= slope_b_reg;
            cu_neg_c_reg <= cu_neg_b_reg;
        end
    end

    // Stage D: curvature, then drop everything for an unsupported setup
    logic [SUM_W-1:0] sum, cu_sh;
    logic             blank;
    logic [OUT_W-1:0] value_reg, slope_reg, curvature_reg;

    always_comb
    begin
        sum = SUM_W'(ll_reg) + (SUM_W'(lh_reg) << LO_W) + (SUM_W'(hl_reg) << C_LO_W)
              + (SUM_W'(hh_reg) << (C_LO_W + LO_W));
        cu_sh = sum >> CU_SH;
        blank = (support != SUPPORT_HINGED && support != SUPPORT_CLAMPED) || (span == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg     <= blank ? '0 : value_c_reg;
            slope_reg     <= blank ? '0 : slope_c_reg;
            curvature_reg <= blank ? '0
                             : sat_q(cu_neg_c_reg, |cu_sh[SUM_W-1:OUT_W-1], cu_sh[OUT_W-2:0]);
        end
    end

    assign value     = value_reg;
    assign slope     = slope_reg;
    assign curvature = curvature_reg;

endmodule

// ===== hdl/plate_trig_basis_eval_unit.sv =====
// Top level of the plate trigonometric basis evaluator: configuration registers,
// the x and y lanes, the valid pipeline and the merged result item. Depends on ptbe_pkg, ptbe_lane.
//
// Takes one item per clock while no result is held and returns one result item per item,
// through one entry stage, 63 divider steps, 24 CORDIC rotations and four product stages.
// The whole pipeline holds while a result waits on m_tready, so s_tready follows
// !m_tvalid || m_tready. Write the configuration only while the pipeline is empty.
module plate_trig_basis_eval_unit
    import ptbe_pkg::*;
#(
    parameter int MAX_MODE  = 64,
    parameter int FRAC_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,   // coord_x[23:0], mode_x[30:24], coord_y[54:31], mode_y[61:55]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [191:0]  m_tdata,   // value_x, slope_x, curvature_x, value_y, slope_y,
                                     // curvature_y, 32 bits each from the lowest bits up
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [23:0]   cfg_data
);

    logic [SPAN_W-1:0]   plate_length_reg, plate_width_reg;
    logic [1:0]          support_mode_reg;
    logic [LANE_LAT-1:0] vld_reg;
    logic                en;

    // Write the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plate_length_reg <= SPAN_RESET;
            plate_width_reg  <= SPAN_RESET;
            support_mode_reg <= SUPPORT_HINGED;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PLATE_LENGTH: plate_length_reg <= cfg_data;
                REG_PLATE_WIDTH:  plate_width_reg  <= cfg_data;
                REG_SUPPORT_MODE: support_mode_reg <= cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    // Advance the pipeline unless a finished item is held
    assign en       = !vld_reg[LANE_LAT-1] || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LANE_LAT-2:0], s_tvalid};
        end
    end

    logic [OUT_W-1:0] vx, sx, cx, vy, sy, cy;

    ptbe_lane #(.MAX_MODE(MAX_MODE), .FRAC_BITS(FRAC_BITS)) u_lane_x
    (
        .clk       (clk),
        .en        (en),
        .coord     (s_tdata[23:0]),
        .mode      (s_tdata[30:24]),
        .span      (plate_length_reg),
        .support   (support_mode_reg),
        .value     (vx),
        .slope     (sx),
        .curvature (cx)
    );

    ptbe_lane #(.MAX_MODE(MAX_MODE), .FRAC_BITS(FRAC_BITS)) u_lane_y
    (
        .clk       (clk),
        .en        (en),
        .coord     (s_tdata[54:31]),
        .mode      (s_tdata[61:55]),
        .span      (plate_width_reg),
        .support   (support_mode_reg),
        .value     (vy),
        .slope     (sy),
        .curvature (cy)
    );

    // Merge both lanes into one result item
    assign m_tvalid = vld_reg[LANE_LAT-1];
    assign m_tdata  = {cy, sy, vy, cx, sx, vx};

endmodule

// ===== hdl/ptbe_chk.sv =====
// Port checker for the plate trigonometric basis evaluator, bound to the top level.
// Depends on ptbe_pkg only through the bound module.
module ptbe_chk
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [63:0]  s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata,
    input logic         cfg_we,
    input logic [1:0]   cfg_index,
    input logic [23:0]  cfg_data
);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item dropped or changed while stalled");

    // Take input exactly when the pipeline can advance
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready out of step with output stall");

    // Start empty after reset
    a_reset_empty: assert property (@(posedge clk)
        !$past(rst_n) |-> !m_tvalid)
        else $error("result item shown straight after reset");

    // Stop input while a result is held
    a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while result held");

endmodule

bind plate_trig_basis_eval_unit ptbe_chk u_ptbe_chk (.*);

// ===== tb/tb_plate_trig_basis_eval_unit.sv =====
// Self-checking testbench for plate_trig_basis_eval_unit: streams coordinate items through
// the block over several plate settings and checks every result item against a local
// fixed-point predictor. Depends on ptbe_pkg and the block itself.
module tb_plate_trig_basis_eval_unit;
    import ptbe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MODE_LIMIT = 64;
    localparam int FRAC       = 16;
    localparam int CYCLE_CAP  = 200000;
    localparam int DRAIN_WAIT = 120;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;   // coord_x[23:0], mode_x[30:24], coord_y[54:31], mode_y[61:55]
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;   // value_x, slope_x, curvature_x, value_y, slope_y, curvature_y
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [23:0]  cfg_data;

    // Local copy of the plate registers
    logic [23:0]  span_x;
    logic [23:0]  span_y;
    logic [1:0]   edge_support;

    logic [63:0]  coord_items[$];
    logic [191:0] basis_expected[$];
    int           sent_count;
    int           recv_count;
    int           mismatches;
    int           cycle_count;
    int           tx_idle;
    int           rx_idle;
    int           hold_left;
    bit           hold_done;

    plate_trig_basis_eval_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // (a*b) >> s on the full product, clipped to 64 bits
    function automatic logic [63:0] wide_mul_shift(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] prod;
        prod = ({64'd0, a} * {64'd0, b}) >> s;
        if (prod[127:64] != 0)
            return {64{1'b1}};
        return prod[63:0];
    endfunction

    function automatic logic [31:0] clip_q(logic neg, logic [63:0] mag);
        if (neg)
            return (mag >= 64'h80000000) ? 32'h80000000 : (32'd0 - mag[31:0]);
        return (mag > 64'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
    endfunction

    function automatic logic [63:0] abs64(logic signed [63:0] v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Basis value, slope and curvature for one axis, packed {curvature, slope, value}
    function automatic logic [95:0] basis_axis(logic [23:0] pos, logic [6:0] cnt,
                                               logic [23:0] span, logic [1:0] sup);
        logic [63:0] m;
        logic [63:0] c;
        logic [63:0] w;
        logic [63:0] ph64;
        logic [31:0] ph;
        logic [31:0] p;
        logic [31:0] quarter;
        logic        flip;
        logic        cneg;
        logic signed [63:0] z;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic signed [63:0] vl;
        logic signed [63:0] st;
        logic signed [63:0] ct;
        logic [31:0] o0;
        logic [31:0] o1;
        logic [31:0] o2;
        if (sup != SUPPORT_HINGED && sup != SUPPORT_CLAMPED || span == 0)
            return '0;
        c = (sup == SUPPORT_CLAMPED) ? 64'd2 : 64'd1;
        m = (cnt > MODE_LIMIT) ? 64'(MODE_LIMIT) : 64'(cnt);
        ph64 = ((m * 64'(pos)) << (30 + c)) / 64'(span);
        ph = ph64[31:0];
        // fold into a quarter turn either side of zero
        quarter = ph + 32'h40000000;
        flip = quarter[31];
        p = flip ? ph - 32'h80000000 : ph;
        z = {{32{p[31]}}, p};
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - $signed(64'(ATAN_TURNS[i]));
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + $signed(64'(ATAN_TURNS[i]));
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        w = ((c * m * 64'(PI_Q28)) << FRAC) / 64'(span);
        if (c == 1)
        begin
            vl = y;
            st = x;
            ct = y;
            cneg = (y >= 0);
        end
        else
        begin
            vl = 64'sd1073741824 - x;
            st = y;
            ct = x;
            cneg = (x < 0);
        end
        o0 = clip_q(vl < 0, abs64(vl) >> (30 - FRAC));
        o1 = clip_q(st < 0, wide_mul_shift(w, abs64(st), 30) >> (28 - FRAC));
        o2 = clip_q(cneg, wide_mul_shift(wide_mul_shift(w, abs64(ct), 30), w, 56 - FRAC));
        return {o2, o1, o0};
    endfunction

    task automatic report_mismatch(string field, int idx, logic [31:0] got, logic [31:0] want);
        $display("mismatch item %0d %s: got %h expected %h", idx, field, got, want);
        mismatches++;
    endtask

    // Sender: offer queued items, predict each one as it is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                basis_expected.push_back({
                    basis_axis(s_tdata[54:31], s_tdata[61:55], span_y, edge_support),
                    basis_axis(s_tdata[23:0], s_tdata[30:24], span_x, edge_support)});
                sent_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (coord_items.size() != 0 && $urandom_range(99) >= tx_idle)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= coord_items.pop_front();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check results, stall at random, one long hold-off early on
    always @(posedge clk or negedge rst_n)
    begin
        logic [191:0] want;
        string names[6];
        names = '{"value_x", "slope_x", "curvature_x", "value_y", "slope_y", "curvature_y"};
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (basis_expected.size() == 0)
                begin
                    $display("unexpected result item %0d", recv_count);
                    mismatches++;
                end
                else
                begin
                    want = basis_expected.pop_front();
                    for (int f = 0; f < 6; f++)
                        if (m_tdata[32*f +: 32] !== want[32*f +: 32])
                            report_mismatch(names[f], recv_count, m_tdata[32*f +: 32],
                                            want[32*f +: 32]);
                end
                recv_count++;
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (!hold_done && sent_count >= 30)
            begin
                hold_done <= 1'b1;
                hold_left <= 400;
                m_tready  <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_idle);
            end
        end
    end

    // Idle profile follows progress through the run
    always @(posedge clk)
    begin
        if (sent_count < 280)
        begin
            tx_idle <= 34;
            rx_idle <= 72;
        end
        else if (sent_count < 560)
        begin
            tx_idle <= 72;
            rx_idle <= 34;
        end
        else
        begin
            tx_idle <= 0;
            rx_idle <= 0;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_PLATE_LENGTH: span_x = val;
            REG_PLATE_WIDTH:  span_y = val;
            default:          edge_support = val[1:0];
        endcase
    endtask

    task automatic drain();
        while (coord_items.size() != 0 || basis_expected.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic [63:0] pack_item(logic [23:0] cx, logic [6:0] mx,
                                              logic [23:0] cy, logic [6:0] my);
        return {2'b00, my, cy, mx, cx};
    endfunction

    // Random items: mostly inside the span with sane counts, some anywhere
    task automatic queue_random(int n);
        logic [23:0] cx;
        logic [23:0] cy;
        logic [6:0]  mx;
        logic [6:0]  my;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(3) != 0)
            begin
                cx = 24'($urandom_range(int'(span_x)));
                cy = 24'($urandom_range(int'(span_y)));
                mx = 7'($urandom_range(MODE_LIMIT));
                my = 7'($urandom_range(MODE_LIMIT));
            end
            else
            begin
                cx = 24'($urandom);
                cy = 24'($urandom);
                mx = 7'($urandom);
                my = 7'($urandom);
            end
            coord_items.push_back(pack_item(cx, mx, cy, my));
        end
    endtask

    task automatic queue_directed();
        coord_items.push_back(pack_item(24'd0, 7'd0, 24'd0, 7'd0));
        coord_items.push_back(pack_item(24'hFFFFFF, 7'd127, 24'hFFFFFF, 7'd127));
        coord_items.push_back(pack_item(24'd0, 7'd1, 24'hFFFFFF, 7'd64));
        coord_items.push_back(pack_item(24'h008000, 7'd1, 24'h004000, 7'd1));
        coord_items.push_back(pack_item(24'h010000, 7'd1, 24'h00C000, 7'd3));
        coord_items.push_back(pack_item(24'h000001, 7'd64, 24'h00FFFF, 7'd64));
        coord_items.push_back(pack_item(24'h012345, 7'd65, 24'h0ABCDE, 7'd100));
        coord_items.push_back(pack_item(24'h00AAAA, 7'd7, 24'h005555, 7'd12));
        coord_items.push_back(pack_item(24'hFFFFFF, 7'd1, 24'd1, 7'd127));
        coord_items.push_back(pack_item(24'h800000, 7'd33, 24'h7FFFFF, 7'd32));
    endtask

    // Stimulus over a series of plate settings
    initial
    begin
        logic [23:0] lens[9];
        logic [23:0] wids[9];
        logic [1:0]  sups[9];
        lens = '{24'd65536, 24'd65536, 24'd1, 24'hFFFFFF, 24'd0, 24'h030000,
                 24'h000100, 24'h0A0000, 24'h020000};
        wids = '{24'd65536, 24'd65536, 24'hFFFFFF, 24'd1, 24'h018000, 24'd0,
                 24'h050000, 24'h0A0000, 24'h020000};
        sups = '{SUPPORT_HINGED, SUPPORT_CLAMPED, SUPPORT_HINGED, SUPPORT_CLAMPED,
                 SUPPORT_HINGED, SUPPORT_CLAMPED, SUPPORT_CLAMPED, 2'd2, 2'd3};
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_PLATE_LENGTH;
        cfg_data     = '0;
        span_x       = SPAN_RESET;
        span_y       = SPAN_RESET;
        edge_support = SUPPORT_HINGED;
        sent_count   = 0;
        recv_count   = 0;
        mismatches   = 0;
        cycle_count  = 0;
        tx_idle      = 34;
        rx_idle      = 72;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // reset settings first
        queue_directed();
        queue_random(60);
        drain();
        for (int ph = 0; ph < 9; ph++)
        begin
            write_reg(REG_PLATE_LENGTH, lens[ph]);
            write_reg(REG_PLATE_WIDTH, wids[ph]);
            write_reg(REG_SUPPORT_MODE, 24'(sups[ph]));
            if (ph < 2)
                queue_directed();
            queue_random(ph >= 7 ? 40 : 90);
            drain();
        end
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== plate_trig_basis_eval_unit.f =====
hdl/ptbe_pkg.sv
hdl/ptbe_div.sv
hdl/ptbe_cordic.sv
hdl/ptbe_lane.sv
hdl/plate_trig_basis_eval_unit.sv
hdl/ptbe_chk.sv
tb/tb_plate_trig_basis_eval_unit.sv
